// ===== rtl/core/pidc_pkg.sv =====
// shared types and constants of the clamped pid regulator
`default_nettype none
package pidc_pkg;

	// register indexes on the configuration port
	localparam logic [3:0] REG_GAIN_P = 4'd0;
	localparam logic [3:0] REG_GAIN_I = 4'd1;
	localparam logic [3:0] REG_GAIN_D = 4'd2;
	localparam logic [3:0] REG_LIMIT_P = 4'd3;
	localparam logic [3:0] REG_LIMIT_I = 4'd4;
	localparam logic [3:0] REG_LIMIT_D = 4'd5;
	localparam logic [3:0] REG_BIAS = 4'd6;
	localparam logic [3:0] REG_CLAMP_EN = 4'd7;

	// milliseconds per second
	localparam logic [15:0] MS_PER_S = 16'd1000;

	// rounding offset and reciprocal of the millisecond scale, ceil(2^57 / 1000)
	localparam logic [15:0] MS_HALF = MS_PER_S >> 1;
	localparam int RECIP_SHIFT = 57;
	localparam logic [23:0] RECIP_LO = 24'h978d50;
	localparam logic [23:0] RECIP_HI = 24'h83126e;

	// divider sizes
	localparam int NUM_W = 48;
	localparam int QUO_W = NUM_W + 1;

	// datapath operations
	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_CLEAR,
		OP_MUL_P,
		OP_ACC_P,
		OP_MUL_I,
		OP_DIV_I,
		OP_ACC_I,
		OP_MUL_IG,
		OP_ACC_IG,
		OP_DIV_D,
		OP_ACC_D,
		OP_MUL_D,
		OP_ACC_D2,
		OP_OUT
	} pidc_op_t;

	typedef struct packed {
		pidc_op_t op;
	} pidc_ctrl_t;

	typedef struct packed {
		logic div_busy;
		logic d_run;
	} pidc_stat_t;

endpackage
`default_nettype wire

// ===== rtl/core/pidc_div.sv =====
// serial restoring divider, one quotient bit a cycle, rounds to nearest
`default_nettype none
module pidc_div (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	input  wire logic [pidc_pkg::NUM_W-1:0]      num,
	input  wire logic [15:0]                     den,
	output logic                                 busy,
	output logic [pidc_pkg::QUO_W-1:0]           quo
);

	logic [pidc_pkg::QUO_W-1:0] quo_q;
	logic [15:0] rem_q;
	logic [15:0] den_q;
	logic [5:0] cnt_q;
	logic busy_q;
	logic [16:0] trial;
	logic [16:0] diff;

	// one trial subtraction per cycle
	always_comb begin
		trial = {rem_q, quo_q[pidc_pkg::QUO_W-1]};
		diff = trial - {1'b0, den_q};
	end

	// iteration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= 6'(pidc_pkg::QUO_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 6'd1;
			busy_q <= (cnt_q != 6'd1);
		end
	end

	// remainder and quotient shift register, biased by half the divisor
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= {1'b0, num} + {{(pidc_pkg::QUO_W-15){1'b0}}, den[15:1]};
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			if (trial >= {1'b0, den_q}) begin
				rem_q <= diff[15:0];
				quo_q <= {quo_q[pidc_pkg::QUO_W-2:0], 1'b1};
			end else begin
				rem_q <= trial[15:0];
				quo_q <= {quo_q[pidc_pkg::QUO_W-2:0], 1'b0};
			end
		end
	end

	assign busy = busy_q;
	assign quo = quo_q;

endmodule
`default_nettype wire

// ===== rtl/core/pidc_datapath.sv =====
// pid datapath: registers, shared multiplier, divider and term arithmetic
`default_nettype none
module pidc_datapath (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire pidc_pkg::pidc_ctrl_t      ctrl,
	output pidc_pkg::pidc_stat_t           stat,
	input  wire logic                      cfg_we,
	input  wire logic [3:0]                cfg_index,
	input  wire logic [31:0]               cfg_data,
	input  wire logic signed [31:0]        error_in,
	input  wire logic [15:0]               interval_ms,
	output logic signed [31:0]             drive
);

	logic signed [31:0] gain_p_q, gain_i_q, gain_d_q, bias_q;
	logic [30:0] limit_p_q, limit_i_q, limit_d_q;
	logic [2:0] clamp_en_q;
	logic signed [31:0] acc_q, last_q, err_q, rate_q, drive_q;
	logic [15:0] ms_q;
	logic signed [65:0] prod_q;
	logic signed [51:0] sum_q;
	logic neg_q;
	logic [47:0] rn_q;
	logic [95:0] racc_q;
	logic [2:0] rcnt_q;

	logic signed [32:0] mul_a, mul_b;
	logic gp_pos, gi_pos, gd_pos;
	logic div_start, div_busy;
	logic [pidc_pkg::NUM_W-1:0] div_num;
	logic [15:0] div_den;
	logic [pidc_pkg::QUO_W-1:0] div_quo;
	logic signed [51:0] quo_s;
	logic signed [65:0] prod_mag;
	logic signed [32:0] diff;
	logic signed [43:0] diff_k;
	logic [43:0] diff_mag;
	logic signed [51:0] p_rnd, x_rnd, acc_sum, acc_new, rate_new;
	logic rbusy;
	logic [1:0] rstep;
	logic [23:0] rmul_a, rmul_b;
	logic [47:0] rprod;
	logic [95:0] rterm;
	logic [pidc_pkg::QUO_W-1:0] rquo;
	logic [pidc_pkg::QUO_W-1:0] qsel;

	function automatic logic signed [51:0] rnd16(input logic signed [65:0] x);
		logic signed [65:0] m;
		logic [65:0] t;
		logic signed [51:0] q;
		m = x[65] ? -x : x;
		t = m + 66'sd32768;
		q = {2'b00, t[65:16]};
		return x[65] ? -q : q;
	endfunction

	function automatic logic signed [51:0] sat32(input logic signed [51:0] x);
		if (x > 52'sd2147483647)
			return 52'sd2147483647;
		else if (x < -52'sd2147483648)
			return -52'sd2147483648;
		else
			return x;
	endfunction

	function automatic logic signed [51:0] clampsym(input logic signed [51:0] x,
			input logic [30:0] lim);
		logic signed [51:0] l;
		logic signed [51:0] r;
		l = {21'b0, lim};
		r = x;
		if (r >= l)
			r = l;
		if (r <= -l)
			r = -l;
		return r;
	endfunction

	// term enables
	assign gp_pos = !gain_p_q[31] && (gain_p_q != '0);
	assign gi_pos = !gain_i_q[31] && (gain_i_q != '0);
	assign gd_pos = !gain_d_q[31] && (gain_d_q != '0);

	// shared multiplier operand select
	always_comb begin
		case (ctrl.op)
			pidc_pkg::OP_MUL_I: begin
				mul_a = {err_q[31], err_q};
				mul_b = $signed({17'b0, ms_q});
			end
			pidc_pkg::OP_MUL_IG: begin
				mul_a = {acc_q[31], acc_q};
				mul_b = {gain_i_q[31], gain_i_q};
			end
			pidc_pkg::OP_MUL_D: begin
				mul_a = {rate_q[31], rate_q};
				mul_b = {gain_d_q[31], gain_d_q};
			end
			default: begin
				mul_a = {err_q[31], err_q};
				mul_b = {gain_p_q[31], gain_p_q};
			end
		endcase
	end

	// reciprocal product for the division by 1000, one partial product a step
	always_comb begin
		rbusy = (rcnt_q != '0);
		rstep = rcnt_q[1:0] - 2'd1;
		rmul_a = rstep[1] ? rn_q[47:24] : rn_q[23:0];
		rmul_b = rstep[0] ? pidc_pkg::RECIP_HI : pidc_pkg::RECIP_LO;
		rprod = rmul_a * rmul_b;
		rterm = {48'b0, rprod};
		if (rstep[1])
			rterm = rterm << 24;
		if (rstep[0])
			rterm = rterm << 24;
		rquo = {{(pidc_pkg::QUO_W - 96 + pidc_pkg::RECIP_SHIFT){1'b0}},
			racc_q[95:pidc_pkg::RECIP_SHIFT]};
	end

	// reciprocal step count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rcnt_q <= '0;
		end else if (ctrl.op == pidc_pkg::OP_DIV_I) begin
			rcnt_q <= 3'd4;
		end else if (rbusy) begin
			rcnt_q <= rcnt_q - 3'd1;
		end
	end

	// rounded numerator and product accumulator
	always_ff @(posedge clk) begin
		if (ctrl.op == pidc_pkg::OP_DIV_I) begin
			rn_q <= prod_mag[47:0] + {32'b0, pidc_pkg::MS_HALF};
			racc_q <= '0;
		end else if (rbusy) begin
			racc_q <= racc_q + rterm;
		end
	end

	// divider operands and signed quotient
	always_comb begin
		prod_mag = prod_q[65] ? -prod_q : prod_q;
		diff = {err_q[31], err_q} - {last_q[31], last_q};
		diff_k = (44'(diff) <<< 10) - (44'(diff) <<< 4) - (44'(diff) <<< 3);
		diff_mag = diff_k[43] ? 44'(-diff_k) : 44'(diff_k);
		div_start = (ctrl.op == pidc_pkg::OP_DIV_D);
		div_num = {4'b0, diff_mag};
		div_den = ms_q;
		qsel = (ctrl.op == pidc_pkg::OP_ACC_I) ? rquo : div_quo;
		quo_s = $signed({3'b0, qsel});
		if (neg_q)
			quo_s = -quo_s;
	end

	// term values
	always_comb begin
		p_rnd = rnd16(prod_q);
		x_rnd = p_rnd;
		if (clamp_en_q[0])
			p_rnd = clampsym(p_rnd, limit_p_q);
		acc_sum = sat32(52'(acc_q) + quo_s);
		acc_new = clamp_en_q[1] ? clampsym(acc_sum, limit_i_q) : acc_sum;
		rate_new = sat32(quo_s);
		if (clamp_en_q[2])
			rate_new = clampsym(rate_new, limit_d_q);
	end

	pidc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.busy   (div_busy),
		.quo    (div_quo)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q <= '0;
			gain_i_q <= '0;
			gain_d_q <= '0;
			limit_p_q <= '0;
			limit_i_q <= '0;
			limit_d_q <= '0;
			bias_q <= '0;
			clamp_en_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pidc_pkg::REG_GAIN_P: gain_p_q <= cfg_data;
				pidc_pkg::REG_GAIN_I: gain_i_q <= cfg_data;
				pidc_pkg::REG_GAIN_D: gain_d_q <= cfg_data;
				pidc_pkg::REG_LIMIT_P: limit_p_q <= cfg_data[30:0];
				pidc_pkg::REG_LIMIT_I: limit_i_q <= cfg_data[30:0];
				pidc_pkg::REG_LIMIT_D: limit_d_q <= cfg_data[30:0];
				pidc_pkg::REG_BIAS: bias_q <= cfg_data;
				pidc_pkg::REG_CLAMP_EN: clamp_en_q <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	// controller state: integral and previous error
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			last_q <= '0;
		end else begin
			case (ctrl.op)
				pidc_pkg::OP_CLEAR: begin
					acc_q <= '0;
					last_q <= '0;
				end
				pidc_pkg::OP_ACC_I: begin
					if (gi_pos)
						acc_q <= acc_new[31:0];
				end
				pidc_pkg::OP_ACC_D2: last_q <= err_q;
				default: ;
			endcase
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		case (ctrl.op)
			pidc_pkg::OP_LOAD: begin
				err_q <= error_in;
				ms_q <= interval_ms;
			end
			pidc_pkg::OP_ACC_P: sum_q <= gp_pos ? p_rnd : '0;
			pidc_pkg::OP_DIV_I: neg_q <= prod_q[65];
			pidc_pkg::OP_ACC_IG: begin
				if (gi_pos)
					sum_q <= sum_q + x_rnd;
			end
			pidc_pkg::OP_DIV_D: neg_q <= diff_k[43];
			pidc_pkg::OP_ACC_D: rate_q <= rate_new[31:0];
			pidc_pkg::OP_ACC_D2: sum_q <= sum_q + x_rnd;
			pidc_pkg::OP_OUT: drive_q <= 32'(sat32(sum_q + 52'(bias_q)));
			default: ;
		endcase
	end

	assign stat.div_busy = div_busy || rbusy;
	assign stat.d_run = gd_pos && (ms_q != '0);
	assign drive = drive_q;

endmodule
`default_nettype wire

// ===== rtl/core/pidc_ctrl.sv =====
// pid sequencer: steps the datapath through the terms of one sample, or issues a clear
`default_nettype none
module pidc_ctrl (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_stall,
	input  wire logic                   command,
	output logic                        out_valid,
	input  wire logic                   out_stall,
	input  wire pidc_pkg::pidc_stat_t   stat,
	output pidc_pkg::pidc_ctrl_t        ctrl
);

	typedef enum logic [3:0] {
		S_IDLE, S_MP, S_AP, S_MI, S_DI, S_WI, S_AI, S_MIG, S_AIG,
		S_DD, S_WD, S_AD, S_MD, S_AD2, S_OUT
	} state_t;

	state_t state_q;
	logic out_valid_q;
	logic accept;
	logic out_free;

	assign accept = in_valid && (state_q == S_IDLE);
	assign out_free = !out_valid_q || !out_stall;

	// operation for the current step
	always_comb begin
		unique case (state_q)
			S_IDLE: begin
				if (!accept)
					ctrl.op = pidc_pkg::OP_NONE;
				else if (command)
					ctrl.op = pidc_pkg::OP_CLEAR;
				else
					ctrl.op = pidc_pkg::OP_LOAD;
			end
			S_MP: ctrl.op = pidc_pkg::OP_MUL_P;
			S_AP: ctrl.op = pidc_pkg::OP_ACC_P;
			S_MI: ctrl.op = pidc_pkg::OP_MUL_I;
			S_DI: ctrl.op = pidc_pkg::OP_DIV_I;
			S_AI: ctrl.op = pidc_pkg::OP_ACC_I;
			S_MIG: ctrl.op = pidc_pkg::OP_MUL_IG;
			S_AIG: ctrl.op = pidc_pkg::OP_ACC_IG;
			S_DD: ctrl.op = pidc_pkg::OP_DIV_D;
			S_AD: ctrl.op = pidc_pkg::OP_ACC_D;
			S_MD: ctrl.op = pidc_pkg::OP_MUL_D;
			S_AD2: ctrl.op = pidc_pkg::OP_ACC_D2;
			S_OUT: ctrl.op = out_free ? pidc_pkg::OP_OUT : pidc_pkg::OP_NONE;
			default: ctrl.op = pidc_pkg::OP_NONE;
		endcase
	end

	// state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept && !command)
						state_q <= S_MP;
				end
				S_MP: state_q <= S_AP;
				S_AP: state_q <= S_MI;
				S_MI: state_q <= S_DI;
				S_DI: state_q <= S_WI;
				S_WI: begin
					if (!stat.div_busy)
						state_q <= S_AI;
				end
				S_AI: state_q <= S_MIG;
				S_MIG: state_q <= S_AIG;
				S_AIG: state_q <= stat.d_run ? S_DD : S_OUT;
				S_DD: state_q <= S_WD;
				S_WD: begin
					if (!stat.div_busy)
						state_q <= S_AD;
				end
				S_AD: state_q <= S_MD;
				S_MD: state_q <= S_AD2;
				S_AD2: state_q <= S_OUT;
				S_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_stall = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	// a run request starts the sequence
	a_run_start: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && !command) |=> (state_q == S_MP))
		else $error("run request did not start the sequence");

	// quotient is settled when it is used
	a_div_settled: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_AI || state_q == S_AD) |-> !stat.div_busy)
		else $error("quotient used while divider busy");

	// a waiting result is never overwritten
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && out_valid_q && out_stall) |=> (state_q == S_OUT))
		else $error("result written over a waiting one");

	// a new result only comes from the output step
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == S_OUT))
		else $error("result raised outside output step");

endmodule
`default_nettype wire

// ===== rtl/core/pid_controller_clamped_terms_core.sv =====
// top level of the clamped pid regulator
// a run request gives its result after the proportional and integral steps, and later with the derivative
// term, whose pass through the serial divider by the interval makes that path the longer one
// throughput: one request at a time; the next is taken while a result waits
// a clear request clears the integral and previous error, leaves the sequencer idle and gives no result
// reset: configuration, integral, previous error and sequencer state are cleared at once
`default_nettype none
module pid_controller_clamped_terms_core (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic               command,
	input  wire logic signed [31:0] error_in,
	input  wire logic [15:0]        interval_ms,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [31:0]      drive,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [3:0]         cfg_index,
	input  wire logic [31:0]        cfg_data
);

	pidc_pkg::pidc_ctrl_t ctrl;
	pidc_pkg::pidc_stat_t stat;

	// configuration is always taken
	assign cfg_ready = 1'b1;

	pidc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.command   (command),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.ctrl      (ctrl)
	);

	pidc_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (ctrl),
		.stat        (stat),
		.cfg_we      (cfg_valid && cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.error_in    (error_in),
		.interval_ms (interval_ms),
		.drive       (drive)
	);

endmodule
`default_nettype wire
